// ===== rtl/tlvd_pkg.sv =====
`default_nettype none

package tlvd_pkg;

    localparam logic [15:0] TYPE_HELLO  = 16'h0001;
    localparam logic [15:0] TYPE_SERIAL = 16'h0101;
    localparam logic [15:0] HELLO_LEN   = 16'd4;

    localparam logic KIND_HELLO  = 1'b0;
    localparam logic KIND_SERIAL = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_HELLO  = 3'd1,
        PH_PORT   = 3'd2,
        PH_DATA   = 3'd3,
        PH_SKIP   = 3'd4
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] client_id;
        logic [15:0] port_id;
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/tlvd_in_reg.sv =====
`default_nettype none

module tlvd_in_reg
    import tlvd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       take,
    output logic            byte_valid,
    output logic [7:0]      byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The stage empties whenever the parser takes its byte, so a new beat can land
    // in the same cycle.
    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

`default_nettype wire

// ===== rtl/tlvd_parser.sv =====
`default_nettype none

module tlvd_parser
    import tlvd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    output result_t         res
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  byte_index_reg, byte_index_next;
    logic [15:0] packet_type_reg, packet_type_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [31:0] id_shift_reg, id_shift_next;
    logic [31:0] stored_id_reg, stored_id_next;
    logic        id_known_reg, id_known_next;
    logic [15:0] port_reg_reg, port_reg_next;

    logic [31:0] id_shifted;
    logic [15:0] port_shifted;
    logic [15:0] rem_shifted;
    logic [15:0] rem_minus2;
    logic        rem_low;

    assign id_shifted   = {id_shift_reg[23:0], rx_byte};
    assign port_shifted = {port_reg_reg[7:0], rx_byte};
    assign rem_shifted  = {remaining_reg[7:0], rx_byte};
    assign rem_minus2   = remaining_reg - 16'd2;
    assign rem_low      = (remaining_reg <= 16'd1);

    always_comb begin
        phase_next       = phase_reg;
        byte_index_next  = byte_index_reg;
        packet_type_next = packet_type_reg;
        remaining_next   = remaining_reg;
        id_shift_next    = id_shift_reg;
        stored_id_next   = stored_id_reg;
        id_known_next    = id_known_reg;
        port_reg_next    = port_reg_reg;
        res_valid        = 1'b0;
        res.kind         = KIND_HELLO;
        res.port_id      = 16'd0;
        res.data_byte    = 8'd0;
        res.data_valid   = 1'b0;
        res.last         = 1'b0;

        if (step) begin
            unique case (phase_reg)
                PH_HELLO: begin
                    id_shift_next = id_shifted;
                    if (byte_index_reg == 2'd3) begin
                        stored_id_next  = id_shifted;
                        id_known_next   = (id_shifted != 32'd0);
                        byte_index_next = 2'd0;
                        phase_next      = PH_HEADER;
                        res_valid       = 1'b1;
                        res.last        = 1'b1;
                    end else begin
                        byte_index_next = byte_index_reg + 2'd1;
                    end
                end
                PH_PORT: begin
                    port_reg_next = port_shifted;
                    if (byte_index_reg == 2'd1) begin
                        byte_index_next = 2'd0;
                        remaining_next  = rem_minus2;
                        if (rem_minus2 == 16'd0) begin
                            // Serial packet with no data bytes still reports once.
                            phase_next  = PH_HEADER;
                            res_valid   = 1'b1;
                            res.kind    = KIND_SERIAL;
                            res.port_id = port_shifted;
                            res.last    = 1'b1;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end else begin
                        byte_index_next = 2'd1;
                    end
                end
                PH_DATA: begin
                    if (rem_low) begin
                        remaining_next = 16'd0;
                        phase_next     = PH_HEADER;
                    end else begin
                        remaining_next = remaining_reg - 16'd1;
                    end
                    res_valid      = 1'b1;
                    res.kind       = KIND_SERIAL;
                    res.port_id    = port_reg_reg;
                    res.data_byte  = rx_byte;
                    res.data_valid = 1'b1;
                    res.last       = rem_low;
                end
                PH_SKIP: begin
                    if (rem_low) begin
                        remaining_next = 16'd0;
                        phase_next     = PH_HEADER;
                    end else begin
                        remaining_next = remaining_reg - 16'd1;
                    end
                end
                default: begin
                    // Header phase; the unused phase codes land here as well.
                    if (byte_index_reg[1] == 1'b0) begin
                        packet_type_next = {packet_type_reg[7:0], rx_byte};
                    end else begin
                        remaining_next = rem_shifted;
                    end
                    if (byte_index_reg == 2'd3) begin
                        byte_index_next = 2'd0;
                        if (packet_type_reg == TYPE_HELLO && rem_shifted == HELLO_LEN) begin
                            phase_next    = PH_HELLO;
                            id_shift_next = 32'd0;
                        end else if (packet_type_reg == TYPE_SERIAL &&
                                     rem_shifted >= 16'd2 && id_known_reg) begin
                            phase_next    = PH_PORT;
                            port_reg_next = 16'd0;
                        end else if (rem_shifted == 16'd0) begin
                            phase_next = PH_HEADER;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        byte_index_next = byte_index_reg + 2'd1;
                    end
                end
            endcase
        end

        res.client_id = stored_id_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HEADER;
            byte_index_reg  <= 2'd0;
            packet_type_reg <= 16'd0;
            remaining_reg   <= 16'd0;
            id_shift_reg    <= 32'd0;
            stored_id_reg   <= 32'd0;
            id_known_reg    <= 1'b0;
            port_reg_reg    <= 16'd0;
        end else begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            packet_type_reg <= packet_type_next;
            remaining_reg   <= remaining_next;
            id_shift_reg    <= id_shift_next;
            stored_id_reg   <= stored_id_next;
            id_known_reg    <= id_known_next;
            port_reg_reg    <= port_reg_next;
        end
    end

    a_hello_done: assert property (@(posedge aclk) disable iff (!aresetn)
        step && phase_reg == PH_HELLO && byte_index_reg == 2'd3
        |=> phase_reg == PH_HEADER && byte_index_reg == 2'd0)
        else $error("hello packet did not return to header phase");

    a_port_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PORT |-> byte_index_reg <= 2'd1)
        else $error("port phase byte index out of range");

    a_data_needs_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PORT || phase_reg == PH_DATA) |-> id_known_reg)
        else $error("serial data parsed without a known id");

    a_known_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        id_known_reg |-> stored_id_reg != 32'd0)
        else $error("id marked known while stored id is zero");

endmodule

`default_nettype wire

// ===== rtl/tlvd_out_reg.sv =====
`default_nettype none

module tlvd_out_reg
    import tlvd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    load,
    input  wire result_t res,
    output logic         room,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign room       = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_ready |-> !load)
        else $error("pending result overwritten");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !res_reg.data_valid |-> res_reg.last)
        else $error("result without data is not marked last");

    a_hello_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && res_reg.kind == KIND_HELLO
        |-> res_reg.port_id == 16'd0 && !res_reg.data_valid)
        else $error("hello result carries port or data");

endmodule

`default_nettype wire

// ===== rtl/tlv_message_deframer.sv =====
`default_nettype none
// Path: an accepted byte waits in the input register, is parsed once the result register
// has room, and any result it causes is registered and presented on the m_ ports.
// Throughput: one byte per cycle, sustained while m_ready stays high; the input
// register and the result register each refill in the cycle they drain.
// Reset: synchronous, active low on aresetn; the parser returns to the header phase
// with no known id, and both registers are emptied.

module tlv_message_deframer
    import tlvd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_kind,
    output logic [31:0]      m_client_id,
    output logic [15:0]      m_port_id,
    output logic [7:0]       m_data_byte,
    output logic             m_data_valid,
    output logic             m_last
);

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       room;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    // A byte is parsed only when the result register can take whatever it produces.
    assign step = byte_valid && room;

    tlvd_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    tlvd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .rx_byte   (byte_data),
        .res_valid (res_valid),
        .res       (res)
    );

    tlvd_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (res_valid),
        .res     (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_kind       = m_res.kind;
    assign m_client_id  = m_res.client_id;
    assign m_port_id    = m_res.port_id;
    assign m_data_byte  = m_res.data_byte;
    assign m_data_valid = m_res.data_valid;
    assign m_last       = m_res.last;

endmodule

`default_nettype wire
